FILE: rtl/core/dob_pkg.sv
// ----------------------------------------------------------------------------
// dob_pkg
// types, constants and calendar helpers for the date offset block
// ----------------------------------------------------------------------------
package dob_pkg;

  localparam int YEAR_BITS   = 14;
  localparam int OFFSET_BITS = 20;
  localparam int YEAR_MAX    = 9999;
  localparam int WEEK_LEN    = 7;
  localparam int MONTHS      = 12;
  localparam int CENTURY     = 100;

  // internal year width, holds YEAR_MAX
  localparam int YI_W   = 14;
  localparam int HI_W   = 7;
  localparam int DOY_W  = 9;
  localparam int CNT_W  = ((OFFSET_BITS > DOY_W) ? OFFSET_BITS : DOY_W) + 1;
  localparam int BIT_W  = $clog2(OFFSET_BITS);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_BITS-1:0]   start_year;
    logic [3:0]             start_month;
    logic [4:0]             start_day;
    logic [2:0]             start_weekday;
    logic [OFFSET_BITS-1:0] offset_days;
    logic                   mode;
  } dob_in_t;

  typedef struct packed {
    logic [YEAR_BITS-1:0] result_year;
    logic [3:0]           result_month;
    logic [4:0]           result_day;
    logic [2:0]           result_weekday;
    logic [1:0]           status;
  } dob_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIELDS,
    S_SPLIT,
    S_MOD7,
    S_DAY,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } dob_state_t;

  typedef struct packed {
    logic load;
    logic split_step;
    logic mod7_step;
    logic walk_init;
    logic year_step;
    logic month_step;
    logic set_invalid;
    logic set_range;
    logic store;
  } dob_cmd_t;

  typedef struct packed {
    logic field_bad;
    logic split_done;
    logic mod7_last;
    logic day_bad;
    logic year_err;
    logic year_done;
    logic month_done;
  } dob_sts_t;

  // leap year from year split into hundreds and remainder
  function automatic logic dob_leap(input logic [YI_W-1:0] ylo, input logic [HI_W-1:0] hi);
    logic res;
    if (ylo != '0) begin
      res = (ylo[1:0] == 2'd0);
    end else begin
      res = (hi[1:0] == 2'd0);
    end
    return res;
  endfunction

  function automatic logic [4:0] dob_dim(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = leap ? 5'd29 : 5'd28;
      default:                                   d = 5'd31;
    endcase
    return d;
  endfunction

  // days of the year before the first of month m
  function automatic logic [DOY_W-1:0] dob_cum(input logic [3:0] m, input logic leap);
    logic [DOY_W-1:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/date_offset_by_days.sv
// ----------------------------------------------------------------------------
// date_offset_by_days
// gregorian date moved forward or backward by a day count, with weekday
// ----------------------------------------------------------------------------
//  channel | ports                        | carries
//  input   | in_valid, in_stall, in_data  | start date, weekday, count, mode
//  result  | out_valid, out_stall, out_data | result date, weekday, status
//
//  one item at a time; from accept to result valid the item goes through field
//  check, year split by hundreds, offset mod 7 bit by bit, day check, year walk
//  and month walk (year walk dominates); a malformed field ends the item early
//  the result register frees the input once the walk is finished
//  a stalled result holds a finished item in the sequencer until it is taken
//  synchronous active-low reset clears the sequencer and the result valid
// ----------------------------------------------------------------------------
module date_offset_by_days (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dob_pkg::dob_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dob_pkg::dob_out_t out_data
);

  dob_pkg::dob_cmd_t cmd;
  dob_pkg::dob_sts_t sts;

  dob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dob_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: rtl/core/dob_ctrl.sv
// ----------------------------------------------------------------------------
// dob_ctrl
// sequencer for the date offset walk and the handshake of both channels
// ----------------------------------------------------------------------------
module dob_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dob_pkg::dob_sts_t sts,
  output dob_pkg::dob_cmd_t cmd
);

  dob_pkg::dob_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != dob_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dob_pkg::S_IDLE: begin
        if (in_valid) state_nxt = dob_pkg::S_FIELDS;
      end
      dob_pkg::S_FIELDS: begin
        state_nxt = sts.field_bad ? dob_pkg::S_FINISH : dob_pkg::S_SPLIT;
      end
      dob_pkg::S_SPLIT: begin
        if (sts.split_done) state_nxt = dob_pkg::S_MOD7;
      end
      dob_pkg::S_MOD7: begin
        if (sts.mod7_last) state_nxt = dob_pkg::S_DAY;
      end
      dob_pkg::S_DAY: begin
        state_nxt = sts.day_bad ? dob_pkg::S_FINISH : dob_pkg::S_YEAR;
      end
      dob_pkg::S_YEAR: begin
        if (sts.year_err) begin
          state_nxt = dob_pkg::S_FINISH;
        end else if (sts.year_done) begin
          state_nxt = dob_pkg::S_MONTH;
        end
      end
      dob_pkg::S_MONTH: begin
        if (sts.month_done) state_nxt = dob_pkg::S_FINISH;
      end
      dob_pkg::S_FINISH: begin
        if (slot_free) state_nxt = dob_pkg::S_IDLE;
      end
      default: state_nxt = dob_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      dob_pkg::S_IDLE:   cmd.load = in_valid;
      dob_pkg::S_FIELDS: cmd.set_invalid = sts.field_bad;
      dob_pkg::S_SPLIT:  cmd.split_step = !sts.split_done;
      dob_pkg::S_MOD7:   cmd.mod7_step = 1'b1;
      dob_pkg::S_DAY: begin
        cmd.set_invalid = sts.day_bad;
        cmd.walk_init   = !sts.day_bad;
      end
      dob_pkg::S_YEAR: begin
        cmd.set_range = sts.year_err;
        cmd.year_step = !sts.year_err;
      end
      dob_pkg::S_MONTH:  cmd.month_step = !sts.month_done;
      dob_pkg::S_FINISH: cmd.store = slot_free;
      default:           cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.store) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dob_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/dob_dp.sv
// ----------------------------------------------------------------------------
// dob_dp
// datapath: year split, offset mod 7, year and month walk, result register
// ----------------------------------------------------------------------------
module dob_dp (
  input  logic              clk,
  input  dob_pkg::dob_in_t  in_data,
  output dob_pkg::dob_out_t out_data,
  input  dob_pkg::dob_cmd_t cmd,
  output dob_pkg::dob_sts_t sts
);

  localparam int YI_W  = dob_pkg::YI_W;
  localparam int HI_W  = dob_pkg::HI_W;
  localparam int CNT_W = dob_pkg::CNT_W;
  localparam int BIT_W = dob_pkg::BIT_W;
  localparam int DOY_W = dob_pkg::DOY_W;
  localparam int OB    = dob_pkg::OFFSET_BITS;

  dob_pkg::dob_in_t  in_r;
  dob_pkg::dob_out_t out_r, out_nxt;
  logic [YI_W-1:0]   yr_r, yr_nxt;
  logic [YI_W-1:0]   ylo_r, ylo_nxt;
  logic [HI_W-1:0]   hi_r, hi_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [2:0]        r7_r, r7_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [1:0]        err_r, err_nxt;

  logic              leap, leap_prev;
  logic [YI_W-1:0]   ylo_dec, ylo_inc;
  logic [HI_W-1:0]   hi_dec, hi_inc;
  logic [DOY_W-1:0]  ylen, ylen_prev, doy;
  logic [4:0]        dim, dim_start;
  logic [CNT_W-1:0]  n_ext;
  logic [3:0]        r7_cat, wk_sum;
  logic [2:0]        wk;
  logic              back;

  assign back  = in_r.mode;
  assign n_ext = CNT_W'(in_r.offset_days);

  assign leap    = dob_pkg::dob_leap(ylo_r, hi_r);
  assign ylo_dec = (ylo_r == '0) ? YI_W'(dob_pkg::CENTURY - 1) : ylo_r - YI_W'(1);
  assign hi_dec  = (ylo_r == '0) ? hi_r - HI_W'(1) : hi_r;
  assign ylo_inc = (ylo_r == YI_W'(dob_pkg::CENTURY - 1)) ? '0 : ylo_r + YI_W'(1);
  assign hi_inc  = (ylo_r == YI_W'(dob_pkg::CENTURY - 1)) ? hi_r + HI_W'(1) : hi_r;
  assign leap_prev = dob_pkg::dob_leap(ylo_dec, hi_dec);

  assign ylen      = DOY_W'(365) + DOY_W'(leap);
  assign ylen_prev = DOY_W'(365) + DOY_W'(leap_prev);
  assign dim       = dob_pkg::dob_dim(mon_r, leap);
  assign dim_start = dob_pkg::dob_dim(in_r.start_month, leap);
  assign doy       = dob_pkg::dob_cum(in_r.start_month, leap)
                     + DOY_W'(in_r.start_day) - DOY_W'(1);

  assign r7_cat = {r7_r, in_r.offset_days[bit_r]};

  assign wk_sum = back ? (4'(in_r.start_weekday) + 4'(dob_pkg::WEEK_LEN) - 4'(r7_r))
                       : (4'(in_r.start_weekday) + 4'(r7_r));
  assign wk     = (wk_sum >= 4'(dob_pkg::WEEK_LEN)) ? 3'(wk_sum - 4'(dob_pkg::WEEK_LEN))
                                                    : wk_sum[2:0];

  // status to the sequencer
  always_comb begin
    sts.field_bad = (int'(in_r.start_year) == 0) ||
                    (int'(in_r.start_year) > dob_pkg::YEAR_MAX) ||
                    (in_r.start_month == 4'd0) ||
                    (in_r.start_month > dob_pkg::MONTH_DEC) ||
                    (in_r.start_weekday == 3'(dob_pkg::WEEK_LEN));
    sts.split_done = (ylo_r < YI_W'(dob_pkg::CENTURY));
    sts.mod7_last  = (bit_r == '0);
    sts.day_bad    = (in_r.start_day == 5'd0) || (in_r.start_day > dim_start);
    if (back) begin
      sts.year_done = (n_ext <= rem_r);
      sts.year_err  = !sts.year_done && (yr_r == YI_W'(1));
    end else begin
      sts.year_done = (rem_r < CNT_W'(ylen));
      sts.year_err  = !sts.year_done && (yr_r == YI_W'(dob_pkg::YEAR_MAX));
    end
    sts.month_done = (mon_r == dob_pkg::MONTH_DEC) || (rem_r < CNT_W'(dim));
  end

  always_comb begin
    yr_nxt  = yr_r;
    ylo_nxt = ylo_r;
    hi_nxt  = hi_r;
    mon_nxt = mon_r;
    rem_nxt = rem_r;
    r7_nxt  = r7_r;
    bit_nxt = bit_r;
    err_nxt = err_r;
    out_nxt = out_r;

    if (cmd.load) begin
      yr_nxt  = YI_W'(in_data.start_year);
      ylo_nxt = YI_W'(in_data.start_year);
      hi_nxt  = '0;
      r7_nxt  = '0;
      bit_nxt = BIT_W'(OB - 1);
      err_nxt = dob_pkg::STATUS_OK;
    end
    if (cmd.split_step) begin
      ylo_nxt = ylo_r - YI_W'(dob_pkg::CENTURY);
      hi_nxt  = hi_r + HI_W'(1);
    end
    if (cmd.mod7_step) begin
      r7_nxt  = (r7_cat >= 4'(dob_pkg::WEEK_LEN)) ? 3'(r7_cat - 4'(dob_pkg::WEEK_LEN))
                                                  : r7_cat[2:0];
      bit_nxt = bit_r - BIT_W'(1);
    end
    if (cmd.walk_init) begin
      mon_nxt = dob_pkg::MONTH_JAN;
      rem_nxt = back ? CNT_W'(doy) : CNT_W'(doy) + n_ext;
    end
    if (cmd.year_step) begin
      if (back) begin
        if (sts.year_done) begin
          rem_nxt = rem_r - n_ext;
        end else begin
          yr_nxt  = yr_r - YI_W'(1);
          ylo_nxt = ylo_dec;
          hi_nxt  = hi_dec;
          rem_nxt = rem_r + CNT_W'(ylen_prev);
        end
      end else if (!sts.year_done) begin
        yr_nxt  = yr_r + YI_W'(1);
        ylo_nxt = ylo_inc;
        hi_nxt  = hi_inc;
        rem_nxt = rem_r - CNT_W'(ylen);
      end
    end
    if (cmd.month_step) begin
      rem_nxt = rem_r - CNT_W'(dim);
      mon_nxt = mon_r + 4'd1;
    end
    if (cmd.set_invalid) err_nxt = dob_pkg::STATUS_INVALID;
    if (cmd.set_range)   err_nxt = dob_pkg::STATUS_RANGE;
    if (cmd.store) begin
      if (err_r != dob_pkg::STATUS_OK) begin
        out_nxt        = '0;
        out_nxt.status = err_r;
      end else begin
        out_nxt.result_year    = dob_pkg::YEAR_BITS'(yr_r);
        out_nxt.result_month   = mon_r;
        out_nxt.result_day     = rem_r[4:0] + 5'd1;
        out_nxt.result_weekday = wk;
        out_nxt.status         = dob_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    yr_r  <= yr_nxt;
    ylo_r <= ylo_nxt;
    hi_r  <= hi_nxt;
    mon_r <= mon_nxt;
    rem_r <= rem_nxt;
    r7_r  <= r7_nxt;
    bit_r <= bit_nxt;
    err_r <= err_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
